FILE: hdl/pif_pkg.sv
// Shared widths, codes and control types of the polyphase interpolation FIR.
`timescale 1ns / 1ps

package pif_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int COEF_W         = 18;
	localparam int IDX_W          = 5;
	localparam int CFG_W          = 4;
	localparam int PHASE_W        = 3;
	localparam int FRAC_SHIFT     = 16;
	localparam int SAMPLE_MAX     = 32767;
	localparam int SAMPLE_MIN     = -32768;

	// sample bits consumed by the multiplier per cycle
	localparam int DIGIT_W        = 4;
	localparam int N_DIGITS       = SAMPLE_W / DIGIT_W;

	localparam int TAPS_DEF       = 31;
	localparam int MAX_FACTOR_DEF = 8;

	localparam logic MODE_COEF    = 1'b0;
	localparam logic MODE_SAMPLE  = 1'b1;

	typedef struct packed {
		logic clr;
		logic load;
		logic step;
	} mac_ctrl_t;

endpackage

FILE: hdl/pif_ram.sv
// Generic single-port-write RAM with one registered read port.
`timescale 1ns / 1ps

module pif_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 31
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/pif_mac.sv
// Digit-serial multiply-accumulate with round-half-up scaling and saturation.
`timescale 1ns / 1ps

module pif_mac #(
	parameter int TAPS = pif_pkg::TAPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pif_pkg::mac_ctrl_t                  ctrl,
	input  logic signed [pif_pkg::COEF_W-1:0]   coef,
	input  logic signed [pif_pkg::SAMPLE_W-1:0] sample,
	output logic                                last_digit,
	output logic signed [pif_pkg::SAMPLE_W-1:0] result
);

	import pif_pkg::*;

	localparam int ACC_W = COEF_W + SAMPLE_W + $clog2(TAPS + 1);
	localparam int DGW   = (N_DIGITS > 1) ? $clog2(N_DIGITS) : 1;
	localparam int SHW   = $clog2(DIGIT_W * N_DIGITS);
	localparam int PRW   = COEF_W + DIGIT_W + 1;
	localparam int RW    = ACC_W + 1;
	localparam int QW    = RW - FRAC_SHIFT;
	localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);
	localparam logic signed [QW-1:0] QMAX = QW'(SAMPLE_MAX);
	localparam logic signed [QW-1:0] QMIN = QW'(SAMPLE_MIN);

	logic signed [COEF_W-1:0] coef_q;
	logic        [SAMPLE_W-1:0] samp_sr_q;
	logic        [DGW-1:0]    dig_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic                     top_digit;
	logic signed [DIGIT_W:0]  digit;
	logic signed [PRW-1:0]    prod;
	logic signed [ACC_W-1:0]  prod_ext;
	logic        [SHW-1:0]    shamt;
	logic signed [RW-1:0]     rnd;
	logic signed [QW-1:0]     q;

	assign top_digit  = (dig_q == DGW'(N_DIGITS - 1));
	assign last_digit = top_digit;

	// only the most significant digit carries the sign
	assign digit = top_digit
		? $signed({samp_sr_q[DIGIT_W-1], samp_sr_q[DIGIT_W-1:0]})
		: $signed({1'b0, samp_sr_q[DIGIT_W-1:0]});
	assign prod     = coef_q * digit;
	assign prod_ext = ACC_W'(prod);
	assign shamt    = SHW'(dig_q) * SHW'(DIGIT_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q <= '0;
			acc_q <= '0;
		end else begin
			if (ctrl.clr) begin
				acc_q <= '0;
			end else if (ctrl.step) begin
				acc_q <= acc_q + (prod_ext <<< shamt);
			end
			if (ctrl.load) begin
				dig_q <= '0;
			end else if (ctrl.step) begin
				dig_q <= dig_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			coef_q    <= coef;
			samp_sr_q <= sample;
		end else if (ctrl.step) begin
			samp_sr_q <= samp_sr_q >> DIGIT_W;
		end
	end

	// Q8.31 back to Q1.15: add half, floor, then clamp
	assign rnd = $signed({acc_q[ACC_W-1], acc_q}) + $signed(RW'(ROUND_HALF));
	assign q   = $signed(rnd[RW-1:FRAC_SHIFT]);

	always_comb begin
		priority if (q > QMAX) begin
			result = SAMPLE_W'(SAMPLE_MAX);
		end else if (q < QMIN) begin
			result = SAMPLE_W'(SAMPLE_MIN);
		end else begin
			result = q[SAMPLE_W-1:0];
		end
	end

endmodule

FILE: hdl/polyphase_interpolation_fir_unit.sv
// Top level of the polyphase FIR interpolator: sequencer, stores and output register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------------
//  in      | input     | in_valid / in_ready       | mode, in_sample, coef_index, coef_value
//  out     | output    | out_valid / out_ready     | out_sample, phase, last
//  cfg     | input     | cfg_we (no wait)          | cfg_data = upsample_factor
//
// A coefficient word is taken while the sequencer stays idle. For a sample word, each tap
// costs a RAM read, a load and one step per digit (N_DIGITS = 4) of the single shared
// digit-serial multiply-accumulate, each phase one check and one write of the output
// register. Reset clears the valid bits of both stores at once, with no clearing pass.
// A stalled output holds the sequencer in its emit step.
`timescale 1ns / 1ps

module polyphase_interpolation_fir_unit #(
	parameter int TAPS       = pif_pkg::TAPS_DEF,
	parameter int MAX_FACTOR = pif_pkg::MAX_FACTOR_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pif_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                mode,
	input  logic signed [pif_pkg::SAMPLE_W-1:0] in_sample,
	input  logic [pif_pkg::IDX_W-1:0]           coef_index,
	input  logic signed [pif_pkg::COEF_W-1:0]   coef_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pif_pkg::SAMPLE_W-1:0] out_sample,
	output logic [pif_pkg::PHASE_W-1:0]         phase,
	output logic                                last
);

	import pif_pkg::*;

	localparam int AW  = $clog2(TAPS);
	localparam int IW  = ((AW > IDX_W) ? AW : IDX_W) + 1;
	localparam int FW  = $clog2(MAX_FACTOR + 1);
	localparam int CW  = $clog2(TAPS + MAX_FACTOR + 1);
	localparam int PW  = (FW > PHASE_W) ? FW : PHASE_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ISSUE = 5'b00010,
		ST_LOAD  = 5'b00100,
		ST_MUL   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [CFG_W-1:0]         factor_q;
	logic [FW-1:0]            p_q;
	logic [CW-1:0]            c_q;
	logic [AW-1:0]            k_q;
	logic [AW-1:0]            wp_q;
	logic [TAPS-1:0]          dvalid_q;
	logic [TAPS-1:0]          cvalid_q;
	logic                     dvld_rd_q;
	logic                     cvld_rd_q;
	logic                     out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic [PHASE_W-1:0]       phase_q;
	logic                     last_q;

	logic [FW-1:0]            f_eff;
	logic [IW-1:0]            idx_ext;
	logic                     idx_ok;
	logic [AW-1:0]            coef_waddr;
	logic [AW-1:0]            wp_n;
	logic [AW-1:0]            coef_raddr;
	logic [AW:0]              dsub;
	logic [AW-1:0]            delay_raddr;
	logic                     tap_left;
	logic                     last_ph;
	logic                     out_free;
	logic                     take;
	logic [FW-1:0]            p_inc;
	logic [PW-1:0]            p_ext;
	logic [COEF_W-1:0]        coef_rdata;
	logic [SAMPLE_W-1:0]      delay_rdata;
	mac_ctrl_t                mac_ctrl;
	logic signed [COEF_W-1:0] mac_coef;
	logic signed [SAMPLE_W-1:0] mac_sample;
	logic                     mac_last;
	logic signed [SAMPLE_W-1:0] mac_result;

	// factor zero acts as one, above the limit as the limit
	always_comb begin
		priority if (factor_q == '0) begin
			f_eff = FW'(1);
		end else if ({1'b0, factor_q} > (CFG_W + 1)'(MAX_FACTOR)) begin
			f_eff = FW'(MAX_FACTOR);
		end else begin
			f_eff = FW'(factor_q);
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign take       = in_valid && in_ready;
	assign idx_ext    = IW'(coef_index);
	assign idx_ok     = idx_ext < IW'(TAPS);
	assign coef_waddr = idx_ext[AW-1:0];
	assign wp_n       = (wp_q == AW'(TAPS - 1)) ? '0 : wp_q + 1'b1;

	// delay_line[k] lives k places behind the newest entry, modulo TAPS
	assign coef_raddr  = c_q[AW-1:0];
	assign dsub        = (wp_q >= k_q) ? ((AW + 1)'(wp_q) - (AW + 1)'(k_q))
		: ((AW + 1)'(wp_q) + (AW + 1)'(TAPS) - (AW + 1)'(k_q));
	assign delay_raddr = dsub[AW-1:0];

	assign tap_left = c_q < CW'(TAPS);
	assign p_inc    = p_q + FW'(1);
	assign last_ph  = (p_inc == f_eff);
	assign out_free = !out_valid_q || out_ready;
	assign p_ext    = PW'(p_q);

	pif_ram #(
		.WIDTH(COEF_W),
		.DEPTH(TAPS)
	) u_coef_ram (
		.clk   (clk),
		.we    (take && (mode == MODE_COEF) && idx_ok),
		.waddr (coef_waddr),
		.wdata (coef_value),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	pif_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(TAPS)
	) u_delay_ram (
		.clk   (clk),
		.we    (take && (mode == MODE_SAMPLE)),
		.waddr (wp_n),
		.wdata (in_sample),
		.raddr (delay_raddr),
		.rdata (delay_rdata)
	);

	// never-written entries read as zero
	assign mac_coef   = cvld_rd_q ? $signed(coef_rdata) : '0;
	assign mac_sample = dvld_rd_q ? $signed(delay_rdata) : '0;

	always_comb begin
		mac_ctrl.clr  = (state_q == ST_IDLE) || ((state_q == ST_EMIT) && out_free);
		mac_ctrl.load = (state_q == ST_LOAD);
		mac_ctrl.step = (state_q == ST_MUL);
	end

	pif_mac #(
		.TAPS(TAPS)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (mac_ctrl),
		.coef       (mac_coef),
		.sample     (mac_sample),
		.last_digit (mac_last),
		.result     (mac_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			factor_q    <= CFG_W'(1);
			p_q         <= '0;
			c_q         <= '0;
			k_q         <= '0;
			wp_q        <= '0;
			dvalid_q    <= '0;
			cvalid_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				factor_q <= cfg_data;
			end
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (mode == MODE_SAMPLE) begin
							wp_q           <= wp_n;
							dvalid_q[wp_n] <= 1'b1;
							p_q            <= '0;
							c_q            <= '0;
							k_q            <= '0;
							state_q        <= ST_ISSUE;
						end else if (idx_ok) begin
							cvalid_q[coef_waddr] <= 1'b1;
						end
					end
				end
				ST_ISSUE: begin
					state_q <= tap_left ? ST_LOAD : ST_EMIT;
				end
				ST_LOAD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mac_last) begin
						c_q     <= c_q + CW'(f_eff);
						k_q     <= k_q + 1'b1;
						state_q <= ST_ISSUE;
					end
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (out_free) begin
						if (last_ph) begin
							state_q <= ST_IDLE;
						end else begin
							p_q     <= p_inc;
							c_q     <= CW'(p_inc);
							k_q     <= '0;
							state_q <= ST_ISSUE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cvld_rd_q <= cvalid_q[coef_raddr];
		dvld_rd_q <= dvalid_q[delay_raddr];
		if ((state_q == ST_EMIT) && out_free) begin
			out_sample_q <= mac_result;
			phase_q      <= p_ext[PHASE_W-1:0];
			last_q       <= last_ph;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign phase      = phase_q;
	assign last       = last_q;

endmodule

FILE: hdl/pif_checker.sv
// Port-level checks of the polyphase FIR interpolator, bound to its top level.
`timescale 1ns / 1ps

module pif_checker #(
	parameter int MAX_FACTOR = pif_pkg::MAX_FACTOR_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                cfg_we,
	input logic [pif_pkg::CFG_W-1:0]           cfg_data,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                mode,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [pif_pkg::SAMPLE_W-1:0] out_sample,
	input logic [pif_pkg::PHASE_W-1:0]         phase,
	input logic                                last
);

	import pif_pkg::*;

	localparam int FW = $clog2(MAX_FACTOR + 1);
	localparam int PW = (FW > PHASE_W) ? FW : PHASE_W;

	logic [CFG_W-1:0]   fact_q;
	logic [FW-1:0]      eff;
	logic [PW-1:0]      eff_m1;
	logic [PHASE_W-1:0] exp_last_phase;

	// track the factor register from the configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fact_q <= CFG_W'(1);
		end else if (cfg_we) begin
			fact_q <= cfg_data;
		end
	end

	always_comb begin
		priority if (fact_q == '0) begin
			eff = FW'(1);
		end else if ({1'b0, fact_q} > (CFG_W + 1)'(MAX_FACTOR)) begin
			eff = FW'(MAX_FACTOR);
		end else begin
			eff = FW'(fact_q);
		end
	end

	assign eff_m1         = PW'(eff - FW'(1));
	assign exp_last_phase = eff_m1[PHASE_W-1:0];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(phase)
			&& $stable(last))
		else $error("stalled output word changed");

	a_last_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> phase == exp_last_phase)
		else $error("last word of a run carries the wrong phase");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (mode == MODE_SAMPLE) |=> !in_ready)
		else $error("input ready while a sample word is being filtered");

	a_coef_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (mode == MODE_COEF) && !out_valid |=> !out_valid)
		else $error("coefficient word produced an output word");

endmodule

bind polyphase_interpolation_fir_unit pif_checker #(
	.MAX_FACTOR(MAX_FACTOR)
) u_pif_checker (.*);
